// ----- hdl/pmppt_pkg.sv -----
// ----------------------------------------------------------------------------
// pmppt_pkg
// Shared types, widths and register indexes of the perturb-and-observe
// maximum power point tracker.
// ----------------------------------------------------------------------------
package pmppt_pkg;

    // Window accumulator width (33 to 64)
    localparam int SUM_WIDTH = 48;

    // Field widths
    localparam int SAMPLE_W    = 32;
    localparam int WINDOW_W    = 15;
    localparam int FLOOR_W     = 31;
    localparam int STEP_W      = 12;
    localparam int CODE_W      = 16;
    localparam int COUNT_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SAMPLES = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_FLOOR    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LIMIT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_START_CODE     = 3'd5;

    // Register reset values
    localparam logic [WINDOW_W-1:0] WINDOW_SAMPLES_RST = 15'd64;
    localparam logic [FLOOR_W-1:0]  NOISE_FLOOR_RST    = 31'd0;
    localparam logic [STEP_W-1:0]   STEP_SIZE_RST      = 12'd16;
    localparam logic [CODE_W-1:0]   UPPER_LIMIT_RST    = 16'd4000;
    localparam logic [CODE_W-1:0]   LOWER_LIMIT_RST    = 16'd100;
    localparam logic [CODE_W-1:0]   START_CODE_RST     = 16'd2048;

    typedef logic signed [SAMPLE_W-1:0]  sample_t;
    typedef logic signed [SUM_WIDTH-1:0] sum_t;
    typedef logic [CODE_W-1:0]           code_t;

    // Saturation bounds of the accumulator
    localparam sum_t SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam sum_t SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [WINDOW_W-1:0] window_samples;
        logic [FLOOR_W-1:0]  noise_floor;
        logic [STEP_W-1:0]   step_size;
        code_t               upper_limit;
        code_t               lower_limit;
        code_t               start_code;
    } cfg_t;

endpackage

// ----- hdl/pmppt_sample_if.sv -----
// ----------------------------------------------------------------------------
// pmppt_sample_if
// Power sample channel: valid/ready handshake carrying one signed sample word.
// ----------------------------------------------------------------------------
interface pmppt_sample_if;
    logic               valid;
    logic               ready;
    pmppt_pkg::sample_t power_sample;

    modport source (output valid, output power_sample, input ready);
    modport sink   (input valid, input power_sample, output ready);
endinterface

// ----- hdl/pmppt_result_if.sv -----
// ----------------------------------------------------------------------------
// pmppt_result_if
// Result channel: valid/ready handshake carrying setpoint and status word.
// ----------------------------------------------------------------------------
interface pmppt_result_if;
    logic               valid;
    logic               ready;
    pmppt_pkg::code_t   dac_setpoint;
    logic               setpoint_updated;
    logic               moving_up;

    modport source (output valid, output dac_setpoint, output setpoint_updated,
                    output moving_up, input ready);
    modport sink   (input valid, input dac_setpoint, input setpoint_updated,
                    input moving_up, output ready);
endinterface

// ----- hdl/pmppt_cfg.sv -----
// ----------------------------------------------------------------------------
// pmppt_cfg
// Configuration register file; write-only, unknown indexes are ignored.
// ----------------------------------------------------------------------------
module pmppt_cfg
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pmppt_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pmppt_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output pmppt_pkg::cfg_t                        cfg
);
    import pmppt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Index decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_SAMPLES: cfg_next.window_samples = cfg_wdata[WINDOW_W-1:0];
                REG_NOISE_FLOOR:    cfg_next.noise_floor    = cfg_wdata[FLOOR_W-1:0];
                REG_STEP_SIZE:      cfg_next.step_size      = cfg_wdata[STEP_W-1:0];
                REG_UPPER_LIMIT:    cfg_next.upper_limit    = cfg_wdata[CODE_W-1:0];
                REG_LOWER_LIMIT:    cfg_next.lower_limit    = cfg_wdata[CODE_W-1:0];
                REG_START_CODE:     cfg_next.start_code     = cfg_wdata[CODE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_samples <= WINDOW_SAMPLES_RST;
            cfg_reg.noise_floor    <= NOISE_FLOOR_RST;
            cfg_reg.step_size      <= STEP_SIZE_RST;
            cfg_reg.upper_limit    <= UPPER_LIMIT_RST;
            cfg_reg.lower_limit    <= LOWER_LIMIT_RST;
            cfg_reg.start_code     <= START_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/pmppt_in_stage.sv -----
// ----------------------------------------------------------------------------
// pmppt_in_stage
// Input register: captures one sample word and holds it until the core
// takes it; refills in the same cycle the core takes.
// ----------------------------------------------------------------------------
module pmppt_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    pmppt_sample_if.sink         sample,
    input  logic                 take,
    output logic                 item_valid,
    output pmppt_pkg::sample_t   item_sample
);
    import pmppt_pkg::*;

    logic    valid_reg;
    sample_t sample_reg;

    // Free when empty or being emptied this cycle
    assign sample.ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            valid_reg <= sample.valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            sample_reg <= sample.power_sample;
        end
    end

    assign item_valid  = valid_reg;
    assign item_sample = sample_reg;

endmodule

// ----- hdl/pmppt_core.sv -----
// ----------------------------------------------------------------------------
// pmppt_core
// Tracker state and result register: saturating window sum, window close,
// direction decision, setpoint step with limit reload.
// ----------------------------------------------------------------------------
module pmppt_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pmppt_pkg::cfg_t      cfg,
    input  logic                 item_valid,
    input  pmppt_pkg::sample_t   item_sample,
    output logic                 take,
    pmppt_result_if.source       result
);
    import pmppt_pkg::*;

    // State
    sum_t               window_sum_reg,   window_sum_next;
    sum_t               previous_sum_reg, previous_sum_next;
    logic [COUNT_W-1:0] count_reg,        count_next;
    logic               dir_up_reg,       dir_up_next;
    code_t              setpoint_reg,     setpoint_next;

    // Result register
    logic               out_valid_reg;
    logic               updated_reg;

    // Datapath
    logic [SUM_WIDTH:0] raw_sum;
    sum_t               sat_sum;
    sum_t               closed_sum;
    logic               close_win;
    logic               sum_dropped;
    logic               dir_mid;
    logic [CODE_W:0]    up_code;
    logic [CODE_W:0]    down_code;
    logic               up_hit;
    logic               down_hit;

    // Take an item when the result slot is free or draining
    assign take = item_valid && (!out_valid_reg || result.ready);

    // Saturating accumulate
    always_comb
    begin
        raw_sum = {window_sum_reg[SUM_WIDTH-1], window_sum_reg}
                + {{(SUM_WIDTH-SAMPLE_W+1){item_sample[SAMPLE_W-1]}}, item_sample};
        if (raw_sum[SUM_WIDTH] != raw_sum[SUM_WIDTH-1])
        begin
            sat_sum = raw_sum[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sat_sum = raw_sum[SUM_WIDTH-1:0];
        end
    end

    // Window close, noise floor and direction decision
    assign close_win  = count_reg > {1'b0, cfg.window_samples};
    assign closed_sum = (sat_sum < $signed({{(SUM_WIDTH-FLOOR_W){1'b0}}, cfg.noise_floor}))
                      ? '0 : sat_sum;
    assign sum_dropped = closed_sum < previous_sum_reg;
    assign dir_mid     = dir_up_reg ^ sum_dropped;

    // Both step candidates; carry or borrow counts as past the limit
    assign up_code   = {1'b0, setpoint_reg} + {{(CODE_W-STEP_W+1){1'b0}}, cfg.step_size};
    assign down_code = {1'b0, setpoint_reg} - {{(CODE_W-STEP_W+1){1'b0}}, cfg.step_size};
    assign up_hit    = up_code[CODE_W] || (up_code[CODE_W-1:0] > cfg.upper_limit);
    assign down_hit  = down_code[CODE_W] || (down_code[CODE_W-1:0] < cfg.lower_limit);

    // Next state
    always_comb
    begin
        window_sum_next   = window_sum_reg;
        previous_sum_next = previous_sum_reg;
        count_next        = count_reg;
        dir_up_next       = dir_up_reg;
        setpoint_next     = setpoint_reg;
        if (take)
        begin
            if (close_win)
            begin
                window_sum_next   = '0;
                previous_sum_next = closed_sum;
                count_next        = COUNT_W'(1);
                if (dir_mid ? up_hit : down_hit)
                begin
                    dir_up_next   = !dir_mid;
                    setpoint_next = cfg.start_code;
                end
                else
                begin
                    dir_up_next   = dir_mid;
                    setpoint_next = dir_mid ? up_code[CODE_W-1:0] : down_code[CODE_W-1:0];
                end
            end
            else
            begin
                window_sum_next = sat_sum;
                count_next      = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_sum_reg   <= '0;
            previous_sum_reg <= '0;
            count_reg        <= COUNT_W'(1);
            dir_up_reg       <= 1'b0;
            setpoint_reg     <= START_CODE_RST;
            out_valid_reg    <= 1'b0;
            updated_reg      <= 1'b0;
        end
        else
        begin
            window_sum_reg   <= window_sum_next;
            previous_sum_reg <= previous_sum_next;
            count_reg        <= count_next;
            dir_up_reg       <= dir_up_next;
            setpoint_reg     <= setpoint_next;
            if (take)
            begin
                out_valid_reg <= 1'b1;
                updated_reg   <= close_win;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word mirrors state after the last taken item
    assign result.valid            = out_valid_reg;
    assign result.dac_setpoint     = setpoint_reg;
    assign result.setpoint_updated = updated_reg;
    assign result.moving_up        = dir_up_reg;

    // Checks
    a_close_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && close_win) |=> (count_reg == COUNT_W'(1)) && (window_sum_reg == '0))
        else $error("window close did not restart the window");

    a_setpoint_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (setpoint_reg != $past(setpoint_reg)) |-> $past(take && close_win))
        else $error("setpoint moved without a window close");

    a_dir_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (dir_up_reg != $past(dir_up_reg)) |-> $past(take && close_win))
        else $error("direction changed without a window close");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg && (updated_reg == $past(close_win)))
        else $error("taken item did not load the result register");

endmodule

// ----- hdl/perturb_observe_mppt_stepper_top.sv -----
// ----------------------------------------------------------------------------
// perturb_observe_mppt_stepper_top
// Perturb-and-observe MPPT setpoint stepper.
// ----------------------------------------------------------------------------
// Each power sample word yields one result word. A sample passes an input
// register and is folded into the saturating window sum when the core takes
// it, where the window-close decision, the direction update and the setpoint
// step are all settled; the result register holds the outcome. The block
// takes one sample per cycle as long as results are taken, limited by the
// accumulate-and-step loop on the tracker state. When window_samples+1
// samples have been summed the window closes, setpoint_updated is set, and
// dac_setpoint/moving_up show the new perturbation. Configuration writes take
// effect at once and should be made while no sample is in flight.
// ----------------------------------------------------------------------------
module perturb_observe_mppt_stepper_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    pmppt_sample_if.sink                           sample,
    pmppt_result_if.source                         result,
    input  logic                                   cfg_we,
    input  logic [pmppt_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pmppt_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import pmppt_pkg::*;

    cfg_t    cfg;
    logic    take;
    logic    item_valid;
    sample_t item_sample;

    // Register file
    pmppt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input register
    pmppt_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .take        (take),
        .item_valid  (item_valid),
        .item_sample (item_sample)
    );

    // Tracker
    pmppt_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_valid  (item_valid),
        .item_sample (item_sample),
        .take        (take),
        .result      (result)
    );

endmodule

// ----- tb/pmppt_tracker_sb_pkg.sv -----
// ----------------------------------------------------------------------------
// pmppt_tracker_sb_pkg
// Scoreboard for the perturb-and-observe tracker: keeps its own copy of the
// registers and tracker state, predicts one result word per accepted sample
// word and compares each result word, field by field, with the oldest one.
// ----------------------------------------------------------------------------
package pmppt_tracker_sb_pkg;

    import pmppt_pkg::*;

    typedef struct {
        code_t setpoint;
        logic  updated;
        logic  up;
    } tracker_word_t;

    class tracker_scoreboard;

        cfg_t               regs;
        sum_t               window_sum;
        sum_t               last_sum;
        logic [COUNT_W-1:0] count;
        logic               dir_up;
        code_t              setpoint;
        tracker_word_t      expected_words[$];
        int unsigned        errors;

        function new();
            regs.window_samples = WINDOW_SAMPLES_RST;
            regs.noise_floor    = NOISE_FLOOR_RST;
            regs.step_size      = STEP_SIZE_RST;
            regs.upper_limit    = UPPER_LIMIT_RST;
            regs.lower_limit    = LOWER_LIMIT_RST;
            regs.start_code     = START_CODE_RST;
            window_sum = '0;
            last_sum   = '0;
            count      = COUNT_W'(1);
            dir_up     = 1'b0;
            setpoint   = START_CODE_RST;
            errors     = 0;
        endfunction

        // Register write; unknown indexes fall through untouched
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WINDOW_SAMPLES: regs.window_samples = data[WINDOW_W-1:0];
                REG_NOISE_FLOOR:    regs.noise_floor    = data[FLOOR_W-1:0];
                REG_STEP_SIZE:      regs.step_size      = data[STEP_W-1:0];
                REG_UPPER_LIMIT:    regs.upper_limit    = data[CODE_W-1:0];
                REG_LOWER_LIMIT:    regs.lower_limit    = data[CODE_W-1:0];
                REG_START_CODE:     regs.start_code     = data[CODE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        // Fold one accepted sample word into the window and queue its result
        function void note_sample(sample_t s);
            logic signed [SUM_WIDTH:0] wide;
            logic [CODE_W:0]           raised;
            tracker_word_t             word;

            // saturating accumulate
            wide = window_sum + s;
            if (wide > SUM_MAX)
                window_sum = SUM_MAX;
            else if (wide < SUM_MIN)
                window_sum = SUM_MIN;
            else
                window_sum = wide[SUM_WIDTH-1:0];

            word.updated = 1'b0;
            if (count > regs.window_samples)
            begin
                // window closes: floor, compare, then perturb
                if (window_sum < $signed({1'b0, regs.noise_floor}))
                    window_sum = '0;
                if (window_sum < last_sum)
                    dir_up = ~dir_up;
                if (dir_up)
                begin
                    // carry out of 16 bits is also past the upper limit
                    raised = {1'b0, setpoint} + regs.step_size;
                    if (raised > regs.upper_limit)
                    begin
                        dir_up   = 1'b0;
                        setpoint = regs.start_code;
                    end
                    else
                        setpoint = raised[CODE_W-1:0];
                end
                else if (setpoint < regs.step_size ||
                         setpoint - regs.step_size < regs.lower_limit)
                begin
                    // underflow counts as below the lower limit
                    dir_up   = 1'b1;
                    setpoint = regs.start_code;
                end
                else
                    setpoint = setpoint - regs.step_size;
                last_sum     = window_sum;
                window_sum   = '0;
                count        = '0;
                word.updated = 1'b1;
            end
            count = count + 1'b1;

            word.setpoint = setpoint;
            word.up       = dir_up;
            expected_words.push_back(word);
        endfunction

        // Compare one result word with the oldest prediction
        function void check_result(code_t sp, logic upd, logic up);
            tracker_word_t want;

            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected: dac_setpoint %0d", sp);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (sp !== want.setpoint)
            begin
                $error("dac_setpoint: expected %0d, got %0d", want.setpoint, sp);
                errors++;
            end
            if (upd !== want.updated)
            begin
                $error("setpoint_updated: expected %0b, got %0b", want.updated, upd);
                errors++;
            end
            if (up !== want.up)
            begin
                $error("moving_up: expected %0b, got %0b", want.up, up);
                errors++;
            end
        endfunction

    endclass

endpackage

// ----- tb/perturb_observe_mppt_stepper_top_test.sv -----
// ----------------------------------------------------------------------------
// perturb_observe_mppt_stepper_top_test
// Drives power sample words into the tracker under random handshake gaps and
// checks every result word against a scoreboard prediction. A short directed
// run covers sample extremes, zero step and window, the noise floor, limit
// carries and underflows and a shrinking window; random phases then track a
// synthetic power curve and plain noise under many register settings.
// ----------------------------------------------------------------------------
module perturb_observe_mppt_stepper_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pmppt_pkg::*;
    import pmppt_tracker_sb_pkg::*;

    typedef logic [CFG_DATA_W-1:0] cfg_word_t;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    localparam sample_t     SAMPLE_MAX    = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t     SAMPLE_MIN    = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam int unsigned RANDOM_PHASES = 10;
    localparam int unsigned PHASE_WORDS   = 105;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned TIMEOUT_NS    = 10_000_000;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    cfg_word_t cfg_wdata;

    bit        steady;
    bit        hold_req;

    tracker_scoreboard sb;

    pmppt_sample_if sample_ch ();
    pmppt_result_if result_ch ();

    perturb_observe_mppt_stepper_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch.sink),
        .result    (result_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Register data with random junk above the field now and then
    function automatic cfg_word_t with_junk(int unsigned v, int unsigned w);
        int unsigned junk;
        junk = ($urandom_range(0, 3) == 0) ? ($urandom << w) : 0;
        return cfg_word_t'(v | junk);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input cfg_word_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        sb.write_reg(idx, data);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one sample word, wait for the handshake, then maybe idle
    task automatic send_word(input sample_t w);
        int unsigned gap;
        sample_ch.valid        <= 1'b1;
        sample_ch.power_sample <= w;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop sending and wait until every predicted word has come back
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result side: random back-pressure plus one long hold-off on request
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned run_left;
        stall_left      = 0;
        run_left        = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                stall_left = LONG_HOLD;
                hold_req   = 1'b0;
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else if (!steady)
                begin
                    run_left   = $urandom_range(0, 24);
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Handshake monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                sb.note_sample(sample_ch.power_sample);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.dac_setpoint, result_ch.setpoint_updated,
                                result_ch.moving_up);
        end
    end

    // Stimulus
    initial
    begin
        int unsigned ph;
        int unsigned k;
        int unsigned win;
        int unsigned step;
        int unsigned lo;
        int unsigned hi;
        int unsigned start_v;
        int unsigned floor_v;
        code_t       peak;
        bit          curve;
        longint      offset;
        longint      pwr;
        sample_t     w;

        sb = new();
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_wdata              = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.power_sample = '0;
        steady                 = 1'b0;
        hold_req               = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sample extremes, two-sample windows at reset settings
        write_reg(REG_WINDOW_SAMPLES, cfg_word_t'(1));
        send_word(SAMPLE_MAX);
        send_word(SAMPLE_MAX);
        send_word(SAMPLE_MIN);
        send_word(SAMPLE_MIN);
        send_word(0);
        send_word(-1);
        send_word(1);
        send_word(0);
        settle();

        // Zero window and zero step
        write_reg(REG_WINDOW_SAMPLES, cfg_word_t'(0));
        write_reg(REG_STEP_SIZE, cfg_word_t'(0));
        send_word(5);
        send_word(3);
        send_word(7);
        settle();

        // Floor at max forces zero sums; limits at the top give carries
        write_reg(REG_NOISE_FLOOR, cfg_word_t'(32'h7FFF_FFFF));
        write_reg(REG_STEP_SIZE, cfg_word_t'(4095));
        write_reg(REG_UPPER_LIMIT, cfg_word_t'(65535));
        write_reg(REG_LOWER_LIMIT, cfg_word_t'(65535));
        write_reg(REG_START_CODE, cfg_word_t'(65535));
        send_word(12345);
        send_word(-7);
        send_word(SAMPLE_MAX);
        settle();

        // Limits at the bottom give underflows
        write_reg(REG_UPPER_LIMIT, cfg_word_t'(0));
        write_reg(REG_LOWER_LIMIT, cfg_word_t'(0));
        write_reg(REG_START_CODE, cfg_word_t'(0));
        send_word(SAMPLE_MIN);
        send_word(99);
        send_word(-99);
        settle();

        // Widest window, then shrink it under the running count
        write_reg(REG_NOISE_FLOOR, cfg_word_t'(0));
        write_reg(REG_WINDOW_SAMPLES, cfg_word_t'(32767));
        send_word(1000);
        send_word(-2000);
        send_word(SAMPLE_MAX);
        settle();
        write_reg(REG_WINDOW_SAMPLES, cfg_word_t'(1));
        send_word(42);
        settle();

        // Random phases
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            steady = (ph == 2 || ph == 7);
            curve  = (ph % 3 != 2);

            case ($urandom_range(0, 9))
                7, 8:    win = $urandom_range(7, 40);
                9:       win = $urandom_range(41, 150);
                default: win = $urandom_range(0, 6);
            endcase
            case ($urandom_range(0, 4))
                0:       floor_v = 0;
                1:       floor_v = 32'h7FFF_FFFF;
                2:       floor_v = $urandom_range(0, 32'h7FFF_FFFF);
                default: floor_v = $urandom_range(0, 1 << 24);
            endcase
            case ($urandom_range(0, 5))
                0:       step = 1;
                1:       step = 4095;
                default: step = $urandom_range(1, 800);
            endcase
            if ($urandom_range(0, 7) == 0)
            begin
                lo = 0;
                hi = 65535;
            end
            else
            begin
                lo = $urandom_range(0, 20000);
                hi = $urandom_range(lo, 65535);
            end
            if ($urandom_range(0, 5) == 0)
                start_v = $urandom_range(0, 65535);
            else
                start_v = $urandom_range(lo, hi);
            peak = code_t'($urandom_range(lo, hi));

            write_reg(REG_WINDOW_SAMPLES, with_junk(win, WINDOW_W));
            write_reg(REG_NOISE_FLOOR, cfg_word_t'(floor_v));
            write_reg(REG_STEP_SIZE, with_junk(step, STEP_W));
            write_reg(REG_UPPER_LIMIT, with_junk(hi, CODE_W));
            write_reg(REG_LOWER_LIMIT, with_junk(lo, CODE_W));
            write_reg(REG_START_CODE, with_junk(start_v, CODE_W));
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                      cfg_word_t'($urandom));

            for (k = 0; k < PHASE_WORDS; k++)
            begin
                // long result hold-off while samples keep coming
                if (ph == 3 && k == 10)
                    hold_req = 1'b1;
                if (curve && $urandom_range(0, 9) != 0)
                begin
                    // concave power curve around the peak code, small noise
                    offset = longint'(sb.setpoint) - longint'(peak);
                    pwr    = (longint'(1) << 30) - ((offset * offset) >>> 2)
                             + longint'($urandom_range(0, 1 << 21)) - (longint'(1) << 20);
                    w      = pwr[SAMPLE_W-1:0];
                end
                else
                begin
                    case ($urandom_range(0, 5))
                        0:       w = SAMPLE_MAX;
                        1:       w = SAMPLE_MIN;
                        2:       w = $signed($urandom_range(0, 200)) - 100;
                        default: w = $urandom;
                    endcase
                end
                send_word(w);
                // sender pauses until everything is back
                if (ph == 5 && k == 50)
                    settle();
            end
            settle();
        end

        repeat (8) @(negedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/pmppt_pkg.sv
hdl/pmppt_sample_if.sv
hdl/pmppt_result_if.sv
hdl/pmppt_cfg.sv
hdl/pmppt_in_stage.sv
hdl/pmppt_core.sv
hdl/perturb_observe_mppt_stepper_top.sv
tb/pmppt_tracker_sb_pkg.sv
tb/perturb_observe_mppt_stepper_top_test.sv
